// File: hw/rtl/mie_pkg.sv
// Package for the modular inverse core: operand width, request and response
// words, and the sequencer state encoding.
// No dependencies.
`default_nettype none

package mie_pkg;

  // Width of the value, the modulus, and the inverse and gcd result fields.
  localparam int unsigned OPERAND_WIDTH = 31;

  // Request word: the number to invert and its modulus.
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] value;
    logic [OPERAND_WIDTH-1:0] modulus;
  } mie_req_t;

  // Response word: reduced coefficient, gcd and the gcd-is-one flag.
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] inverse;
    logic [OPERAND_WIDTH-1:0] common_divisor;
    logic                     invertible;
  } mie_rsp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDiv,
    StUpdate,
    StRedDiv,
    StFinish
  } mie_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/modular_inverse_ext_euclid_core.sv
// Modular inverse core: iterative extended Euclid on one shared
// shift-subtract divider. Depends on mie_pkg.
`default_nettype none

// Usage:
// A request word (value, modulus) is taken at a rising edge where start_i is
// high and busy_o is low. busy_o stays high until the result is ready, and no
// new word is taken meanwhile. The response word appears on rsp_o for exactly
// one cycle with done_o high; the receiver cannot hold it off, so it must
// capture it in that cycle. A new start may be given in the same cycle.
// The response holds the first Bezout coefficient of value reduced into
// 0..modulus-1, gcd(value, modulus) and a flag set when the gcd is one.
// Each Euclid step runs the divider once, through StCheck, StDiv and StUpdate;
// StCheck and StUpdate do the bookkeeping. The final reduction of the
// coefficient takes one more divider pass, in StRedDiv.
// The single divider yields one quotient bit per cycle and folds the
// quotient-times-coefficient product in by the same bit.
// Reset clears the sequencer and the strobe; the block then waits idle.
module modular_inverse_ext_euclid_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire mie_pkg::mie_req_t req_i,
  output logic                  done_o,
  output mie_pkg::mie_rsp_t     rsp_o
);

  localparam int unsigned W   = mie_pkg::OPERAND_WIDTH;
  // Dividend width: one bit more so a coefficient magnitude of up to 2^W fits.
  localparam int unsigned DW  = W + 1;
  // Signed coefficient width with headroom.
  localparam int unsigned CW  = W + 2;
  localparam int unsigned CNW = $clog2(DW);
  localparam logic [CNW-1:0] CntLast = CNW'(DW - 1);

  mie_pkg::mie_state_e state_q, state_d;

  logic [W-1:0]         r0_q, r0_d, r1_q, r1_d;
  logic signed [CW-1:0] s0_q, s0_d, s1_q, s1_d;
  logic signed [CW-1:0] t_q, t_d;
  logic [W-1:0]         mod_q, mod_d;
  logic [W-1:0]         dsr_q, dsr_d;
  logic [W-1:0]         rem_q, rem_d;
  logic [DW-1:0]        dvd_q, dvd_d;
  logic [CNW-1:0]       cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 done_q, done_d;
  mie_pkg::mie_rsp_t    rsp_q, rsp_d;

  // Shared divider step: one restoring quotient bit per cycle.
  logic [W:0]           div_shift;
  logic [W:0]           div_diff;
  logic                 div_ge;
  logic [W-1:0]         div_rem;
  logic signed [CW-1:0] div_acc;
  logic signed [CW-1:0] s0_neg;
  logic [W-1:0]         red_res;

  assign div_shift = {rem_q, dvd_q[DW-1]};
  assign div_diff  = div_shift - {1'b0, dsr_q};
  assign div_ge    = (div_shift >= {1'b0, dsr_q});
  assign div_rem   = div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
  // Horner accumulation of quotient times the current coefficient.
  assign div_acc   = (t_q <<< 1) + (div_ge ? s1_q : CW'(0));
  assign s0_neg    = -s0_q;

  // Fold a negative coefficient back into 0..modulus-1; a zero modulus gives 0.
  always_comb begin
    if (mod_q == '0) begin
      red_res = '0;
    end else if (neg_q && (rem_q != '0)) begin
      red_res = mod_q - rem_q;
    end else begin
      red_res = rem_q;
    end
  end

  // Sequencer: next state and next values of the working registers.
  always_comb begin
    state_d = state_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    t_d     = t_q;
    mod_d   = mod_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;

    case (state_q)
      mie_pkg::StIdle: begin
        if (start_i) begin
          r0_d    = req_i.modulus;
          r1_d    = req_i.value;
          s0_d    = '0;
          s1_d    = CW'(1);
          mod_d   = req_i.modulus;
          state_d = mie_pkg::StCheck;
        end
      end
      mie_pkg::StCheck: begin
        // A zero remainder ends the Euclid chain; r0 is then the gcd.
        rem_d = '0;
        t_d   = '0;
        cnt_d = CntLast;
        if (r1_q != '0) begin
          dvd_d   = {1'b0, r0_q};
          dsr_d   = r1_q;
          state_d = mie_pkg::StDiv;
        end else if (mod_q == '0) begin
          state_d = mie_pkg::StFinish;
        end else begin
          neg_d   = s0_q[CW-1];
          dvd_d   = s0_q[CW-1] ? s0_neg[DW-1:0] : s0_q[DW-1:0];
          dsr_d   = mod_q;
          state_d = mie_pkg::StRedDiv;
        end
      end
      mie_pkg::StDiv: begin
        rem_d = div_rem;
        t_d   = div_acc;
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q - CNW'(1);
        if (cnt_q == '0) begin
          state_d = mie_pkg::StUpdate;
        end
      end
      mie_pkg::StUpdate: begin
        // Shift the remainder and coefficient sequences by one step.
        r0_d    = r1_q;
        r1_d    = rem_q;
        s0_d    = s1_q;
        s1_d    = s0_q - t_q;
        state_d = mie_pkg::StCheck;
      end
      mie_pkg::StRedDiv: begin
        rem_d = div_rem;
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q - CNW'(1);
        if (cnt_q == '0) begin
          state_d = mie_pkg::StFinish;
        end
      end
      mie_pkg::StFinish: begin
        rsp_d.inverse        = red_res;
        rsp_d.common_divisor = r0_q;
        rsp_d.invertible     = (r0_q == W'(1));
        done_d               = 1'b1;
        state_d              = mie_pkg::StIdle;
      end
      default: begin
        state_d = mie_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mie_pkg::StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    s0_q  <= s0_d;
    s1_q  <= s1_d;
    t_q   <= t_d;
    mod_q <= mod_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != mie_pkg::StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
